### hdl/osct_pkg.sv
// ----------------------------------------------------------------------------
// osct_pkg
// Shared types, register map and microprogram of the overdrive/tone unit.
// ----------------------------------------------------------------------------
package osct_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;

	localparam logic [2:0] REG_DRIVE  = 3'd0;
	localparam logic [2:0] REG_TONE   = 3'd1;
	localparam logic [2:0] REG_LEVEL  = 3'd2;
	localparam logic [2:0] REG_COEFF  = 3'd3;
	localparam logic [2:0] REG_BYPASS = 3'd4;

	localparam logic [15:0] DRIVE_RST = 16'h8000;
	localparam logic [15:0] TONE_RST  = 16'h8000;
	localparam logic [15:0] LEVEL_RST = 16'h8000;
	localparam logic [15:0] COEFF_RST = 16'h0000;

	// shared multiplier: signed A by unsigned B
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = 64;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_MUL_POS,
		OP_IDX,
		OP_LDA,
		OP_MUL_INT,
		OP_CLIP,
		OP_MUL_F1,
		OP_UPD_F1,
		OP_MUL_F2,
		OP_UPD_F2,
		OP_MUL_MIX,
		OP_UPD_MIX,
		OP_MUL_LVL,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_ACCEPT,
		JC_OUTFREE
	} jc_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic [15:0] drive;
		logic [15:0] tone;
		logic [15:0] level;
		logic [15:0] coeff;
		logic        bypass;
	} cfg_t;

	typedef struct packed {
		op_t  op;
		logic take;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic bypass;
		logic out_free;
	} stat_t;

	localparam step_t STEP_IDLE = 4'd0;
	localparam step_t STEP_EMIT = 4'd13;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			4'd0:    w = '{op: OP_IDLE,    jc: JC_ACCEPT,  target: STEP_EMIT};
			4'd1:    w = '{op: OP_MUL_POS, jc: JC_NEXT,    target: STEP_IDLE};
			4'd2:    w = '{op: OP_IDX,     jc: JC_NEXT,    target: STEP_IDLE};
			4'd3:    w = '{op: OP_LDA,     jc: JC_NEXT,    target: STEP_IDLE};
			4'd4:    w = '{op: OP_MUL_INT, jc: JC_NEXT,    target: STEP_IDLE};
			4'd5:    w = '{op: OP_CLIP,    jc: JC_NEXT,    target: STEP_IDLE};
			4'd6:    w = '{op: OP_MUL_F1,  jc: JC_NEXT,    target: STEP_IDLE};
			4'd7:    w = '{op: OP_UPD_F1,  jc: JC_NEXT,    target: STEP_IDLE};
			4'd8:    w = '{op: OP_MUL_F2,  jc: JC_NEXT,    target: STEP_IDLE};
			4'd9:    w = '{op: OP_UPD_F2,  jc: JC_NEXT,    target: STEP_IDLE};
			4'd10:   w = '{op: OP_MUL_MIX, jc: JC_NEXT,    target: STEP_IDLE};
			4'd11:   w = '{op: OP_UPD_MIX, jc: JC_NEXT,    target: STEP_IDLE};
			4'd12:   w = '{op: OP_MUL_LVL, jc: JC_NEXT,    target: STEP_IDLE};
			4'd13:   w = '{op: OP_EMIT,    jc: JC_OUTFREE, target: STEP_IDLE};
			default: w = '{op: OP_NOP,     jc: JC_NEXT,    target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

### hdl/osct_in_if.sv
// ----------------------------------------------------------------------------
// osct_in_if
// Sample input channel: valid/ready with one audio sample per transfer.
// ----------------------------------------------------------------------------
interface osct_in_if #(parameter int SW = 24);
	logic          valid;
	logic          ready;
	logic [SW-1:0] in_sample;
	logic          block_last;

	modport source(output valid, in_sample, block_last, input ready);
	modport sink(input valid, in_sample, block_last, output ready);
endinterface

### hdl/osct_out_if.sv
// ----------------------------------------------------------------------------
// osct_out_if
// Result channel: valid/ready with one processed sample per transfer.
// ----------------------------------------------------------------------------
interface osct_out_if #(parameter int SW = 24);
	logic          valid;
	logic          ready;
	logic [SW-1:0] out_sample;
	logic          out_block_last;

	modport source(output valid, out_sample, out_block_last, input ready);
	modport sink(input valid, out_sample, out_block_last, output ready);
endinterface

### hdl/overdrive_soft_clip_tone_unit.sv
// ----------------------------------------------------------------------------
// overdrive_soft_clip_tone_unit
// tanh soft-clip overdrive with two-stage one-pole tone filter and level.
//
// Channel     Dir  Handshake          Payload
// samples     in   valid/ready        in_sample, block_last
// processed   out  valid/ready        out_sample, out_block_last
// apb         in   psel/penable/pwr   five registers at byte address 4*i
//
// A sample passes through the microcode steps from its transfer to its result,
// with seven steps on the shared 33x32 multiplier.
// In bypass a sample goes from the idle step straight to the emit step.
// The next sample is taken while the previous result waits in the output
// register; the emit step holds until that register is free.
// Reset sets the configuration defaults and clears filter memories, output
// valid and step counter; the tanh table is a constant ROM with no fill pass.
// ----------------------------------------------------------------------------
module overdrive_soft_clip_tone_unit import osct_pkg::*; #(
	parameter int SAMPLE_WIDTH     = 24,
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	osct_in_if.sink               samples,
	osct_out_if.source            processed,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW = $clog2(TANH_TABLE_DEPTH + 1);

	logic [15:0]   drive_q;
	logic [15:0]   tone_q;
	logic [15:0]   level_q;
	logic [15:0]   coeff_q;
	logic          bypass_q;
	logic          cfg_wr;
	logic [2:0]    reg_idx;
	cfg_t          cfg;
	stat_t         stat;
	ctl_t          ctl;
	logic [AW-1:0] rom_addr;
	logic [31:0]   rom_data;
	logic          out_free;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= DRIVE_RST;
			tone_q   <= TONE_RST;
			level_q  <= LEVEL_RST;
			coeff_q  <= COEFF_RST;
			bypass_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DRIVE:  drive_q  <= pwdata[15:0];
				REG_TONE:   tone_q   <= pwdata[15:0];
				REG_LEVEL:  level_q  <= pwdata[15:0];
				REG_COEFF:  coeff_q  <= pwdata[15:0];
				REG_BYPASS: bypass_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DRIVE:  prdata = CFG_DATA_W'(drive_q);
			REG_TONE:   prdata = CFG_DATA_W'(tone_q);
			REG_LEVEL:  prdata = CFG_DATA_W'(level_q);
			REG_COEFF:  prdata = CFG_DATA_W'(coeff_q);
			REG_BYPASS: prdata = CFG_DATA_W'(bypass_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg  = '{drive: drive_q, tone: tone_q, level: level_q, coeff: coeff_q,
		bypass: bypass_q};
	assign stat = '{in_valid: samples.valid, bypass: bypass_q, out_free: out_free};

	assign samples.ready = (ctl.op == OP_IDLE);

	osct_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	osct_tanh_rom #(
		.DEPTH (TANH_TABLE_DEPTH),
		.AW    (AW)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	osct_dp #(
		.SW    (SAMPLE_WIDTH),
		.DEPTH (TANH_TABLE_DEPTH),
		.AW    (AW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg        (cfg),
		.in_sample  (samples.in_sample),
		.in_last    (samples.block_last),
		.rom_data   (rom_data),
		.rom_addr   (rom_addr),
		.out_ready  (processed.ready),
		.out_valid  (processed.valid),
		.out_sample (processed.out_sample),
		.out_last   (processed.out_block_last),
		.out_free   (out_free)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> !samples.ready)
		else $error("input taken again before the current sample finished");

	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> (samples.ready && processed.valid))
		else $error("emit step did not load output and return to idle");

	a_rom_range: assert property (@(posedge clk) disable iff (!arst_n)
		rom_addr <= AW'(TANH_TABLE_DEPTH))
		else $error("tanh table address past last entry");

endmodule

### hdl/osct_tanh_rom.sv
// ----------------------------------------------------------------------------
// osct_tanh_rom
// Constant tanh table, unsigned Q0.32 over u = 0..8, registered read.
// ----------------------------------------------------------------------------
module osct_tanh_rom #(
	parameter int DEPTH = 256,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	output logic [31:0]   data
);

	localparam logic [63:0] ONE = 64'd1 << 31;

	typedef logic [31:0] tab_t [DEPTH+1];

	// shift-subtract division, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-2u) stepped by a series-built factor, tanh = (1-e)/(1+e)
	function automatic tab_t build_tab();
		tab_t        tab;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		logic [63:0] e;
		y    = udiv(64'd1 << 35, 64'(DEPTH));
		term = ONE;
		sum  = ONE;
		for (int n = 1; n <= 12; n++) begin
			term = udiv((term * y) >> 31, 64'(n));
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r = sum;
		e = ONE;
		for (int k = 0; k <= DEPTH; k++) begin
			tab[k] = 32'(udiv((ONE - e) << 32, ONE + e));
			e      = (e * r + (64'd1 << 30)) >> 31;
		end
		return tab;
	endfunction

	localparam tab_t TAB = build_tab();

	always_ff @(posedge clk) begin
		data <= TAB[addr];
	end

endmodule

### hdl/osct_seq.sv
// ----------------------------------------------------------------------------
// osct_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module osct_seq import osct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	step_t  step_q;
	step_t  step_d;
	uword_t uw;
	logic   take;
	logic   emit;

	assign uw   = ucode(step_q);
	assign take = (uw.op == OP_IDLE) && stat.in_valid;
	assign emit = (uw.jc == JC_OUTFREE) && stat.out_free;

	always_comb begin
		step_d = step_q;
		unique case (uw.jc)
			JC_NEXT:    step_d = step_q + 1'b1;
			JC_ACCEPT: begin
				if (take) begin
					step_d = stat.bypass ? uw.target : step_q + 1'b1;
				end
			end
			JC_OUTFREE: begin
				if (stat.out_free) begin
					step_d = uw.target;
				end
			end
			default:    step_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	assign ctl = '{op: uw.op, take: take, emit: emit};

endmodule

### hdl/osct_dp.sv
// ----------------------------------------------------------------------------
// osct_dp
// Datapath: shared multiplier, clip/filter/mix registers, output register.
// ----------------------------------------------------------------------------
module osct_dp import osct_pkg::*; #(
	parameter int SW    = 24,
	parameter int DEPTH = 256,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_t          ctl,
	input  cfg_t          cfg,
	input  logic [SW-1:0] in_sample,
	input  logic          in_last,
	input  logic [31:0]   rom_data,
	output logic [AW-1:0] rom_addr,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [SW-1:0] out_sample,
	output logic          out_last,
	output logic          out_free
);

	localparam int F = SW - 1;
	localparam logic signed [PROD_W-1:0] Y_MAX = PROD_W'((64'sd1 <<< F) - 64'sd1);
	localparam logic signed [PROD_W-1:0] Y_MIN = -Y_MAX - PROD_W'(64'sd1);

	logic signed [SW-1:0]       s_q;
	logic                       last_q;
	logic                       byp_q;
	logic                       neg_q;
	logic [SW-1:0]              mag_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [AW-1:0]              idx_q;
	logic [15:0]                fr_q;
	logic [31:0]                ta_q;
	logic signed [SW-1:0]       c_q;
	logic signed [SW-1:0]       m1_q;
	logic signed [SW-1:0]       m2_q;
	logic                       ovalid_q;
	logic [SW-1:0]              osample_q;
	logic                       olast_q;

	logic [17:0]                gain;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]         mul_b;
	logic signed [MUL_A_W+MUL_B_W:0] mul_p;
	logic signed [SW:0]         dif;
	logic [31:0]                tdiff;
	logic [PROD_W-1:0]          pos_hi;
	logic                       ovf;
	logic [AW-1:0]              idx_addr;
	logic [15:0]                fr_d;
	logic [32:0]                t_sum;
	logic [33:0]                t_rnd;
	logic [33:0]                cmag;
	logic signed [SW-1:0]       cpos;
	logic signed [SW-1:0]       upd;
	logic signed [PROD_W-1:0]   yw;
	logic signed [SW-1:0]       ysat;

	assign gain  = 18'h10000 + {2'b00, cfg.drive} + {1'b0, cfg.drive, 1'b0};
	assign tdiff = rom_data - ta_q;

	always_comb begin
		dif = '0;
		unique case (ctl.op)
			OP_MUL_F1:  dif = (SW+1)'(m1_q) - (SW+1)'(c_q);
			OP_MUL_F2:  dif = (SW+1)'(m2_q) - (SW+1)'(m1_q);
			OP_MUL_MIX: dif = (SW+1)'(m2_q) - (SW+1)'(c_q);
			default:    dif = '0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.op)
			OP_IDLE: begin
				mul_a = $signed(MUL_A_W'(gain));
				mul_b = MUL_B_W'(DEPTH);
			end
			OP_MUL_POS: begin
				mul_a = $signed(MUL_A_W'(mag_q));
				mul_b = prod_q[MUL_B_W-1:0];
			end
			OP_MUL_INT: begin
				mul_a = $signed(MUL_A_W'(tdiff));
				mul_b = MUL_B_W'(fr_q);
			end
			OP_MUL_F1, OP_MUL_F2: begin
				mul_a = MUL_A_W'(dif);
				mul_b = MUL_B_W'(cfg.coeff);
			end
			OP_MUL_MIX: begin
				mul_a = MUL_A_W'(dif);
				mul_b = MUL_B_W'(cfg.tone);
			end
			OP_MUL_LVL: begin
				mul_a = MUL_A_W'(c_q);
				mul_b = MUL_B_W'(cfg.level);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// table position: integer part and 16-bit fraction
	assign pos_hi   = $unsigned(prod_q) >> (F + 18);
	assign ovf      = pos_hi >= PROD_W'(DEPTH);
	assign idx_addr = ovf ? AW'(DEPTH) : pos_hi[AW-1:0];
	assign fr_d     = ovf ? 16'd0 : prod_q[F+17 -: 16];

	always_comb begin
		unique case (ctl.op)
			OP_IDX:  rom_addr = idx_addr;
			OP_LDA:  rom_addr = (idx_q == AW'(DEPTH)) ? idx_q : idx_q + 1'b1;
			default: rom_addr = '0;
		endcase
	end

	// round half up to Q1.F, sign applied afterwards
	assign t_sum = {1'b0, ta_q} + {1'b0, prod_q[47:16]};
	assign t_rnd = 34'(t_sum) + (34'd1 << (32 - F));
	assign cmag  = t_rnd >> (33 - F);
	assign cpos  = $signed(SW'(cmag));

	assign upd = SW'(prod_q >>> 16);

	always_comb begin
		yw = prod_q >>> 15;
		if (yw > Y_MAX) begin
			ysat = SW'(Y_MAX);
		end else if (yw < Y_MIN) begin
			ysat = SW'(Y_MIN);
		end else begin
			ysat = SW'(yw);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_IDLE: begin
				prod_q <= PROD_W'(mul_p);
				if (ctl.take) begin
					s_q    <= $signed(in_sample);
					last_q <= in_last;
					byp_q  <= cfg.bypass;
					neg_q  <= in_sample[SW-1];
					mag_q  <= in_sample[SW-1] ? SW'(-in_sample) : in_sample;
				end
			end
			OP_MUL_POS, OP_MUL_INT, OP_MUL_F1, OP_MUL_F2, OP_MUL_MIX, OP_MUL_LVL: begin
				prod_q <= PROD_W'(mul_p);
			end
			OP_IDX: begin
				idx_q <= idx_addr;
				fr_q  <= fr_d;
			end
			OP_LDA:     ta_q <= rom_data;
			OP_CLIP:    c_q  <= neg_q ? -cpos : cpos;
			OP_UPD_MIX: c_q  <= c_q + upd;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_q <= '0;
			m2_q <= '0;
		end else if (ctl.op == OP_UPD_F1) begin
			m1_q <= c_q + upd;
		end else if (ctl.op == OP_UPD_F2) begin
			m2_q <= m1_q + upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			osample_q <= byp_q ? s_q : ysat;
			olast_q   <= last_q;
		end
	end

	assign out_free   = !ovalid_q || out_ready;
	assign out_valid  = ovalid_q;
	assign out_sample = osample_q;
	assign out_last   = olast_q;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the overdrive/tone unit end to end. Samples go in through a bursty
// valid/ready source and results are taken by a sink that stalls. Each
// result is compared with a bit-exact fixed-point model of the soft clipper,
// the two tone stages, the mix and the level. APB writes and reads cover
// every register and oversized values, and writes go to unmapped addresses.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import osct_pkg::*;

	localparam int SW           = 24;
	localparam int FRAC         = SW - 1;
	localparam int TANH_DEPTH   = 256;
	localparam int HALF_PERIOD  = 4;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_MAX    = 40;
	localparam longint unsigned ONE_Q31 = 64'd1 << 31;
	localparam longint SAMPLE_MAX = (longint'(1) << FRAC) - 1;
	localparam longint SAMPLE_MIN = -(longint'(1) << FRAC);

	typedef struct packed {
		logic [SW-1:0] sample;
		logic          last;
	} audio_t;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	osct_in_if  #(.SW(SW)) in_if();
	osct_out_if #(.SW(SW)) out_if();

	overdrive_soft_clip_tone_unit #(
		.SAMPLE_WIDTH(SW),
		.TANH_TABLE_DEPTH(TANH_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_if),
		.processed(out_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	audio_t            dry_q[$];
	audio_t            wet_q[$];
	longint unsigned   tanh_rom[0:TANH_DEPTH];
	int                drive_set;
	int                tone_set;
	int                level_set;
	int                coeff_set;
	int                bypass_set;
	longint            stage1_mem;
	longint            stage2_mem;
	int                errors = 0;
	int                cycle_cnt = 0;
	bit                dry_taken = 1'b0;
	int                gap_left = 0;
	int                burst_left = 1;
	rx_mode_t          rx_mode = RX_OPEN;
	int                rx_left = 0;
	int                rx_tick = 0;

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		if (errors < PRINT_MAX)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// tanh(8k/N) in Q0.32, exp(-2u) stepped by a series-derived factor
	function automatic void build_tanh_rom();
		longint unsigned step_in;
		longint unsigned term;
		longint unsigned factor;
		longint unsigned e;
		longint          sum;
		step_in = (64'd1 << 35) / TANH_DEPTH;
		term = ONE_Q31;
		sum = longint'(ONE_Q31);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * step_in) >> 31) / n;
			if (n % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		factor = sum;
		e = ONE_Q31;
		for (int k = 0; k <= TANH_DEPTH; k++) begin
			tanh_rom[k] = ((ONE_Q31 - e) << 32) / (ONE_Q31 + e);
			e = (e * factor + (64'd1 << 30)) >> 31;
		end
	endfunction

	function automatic logic [SW-1:0] shape_sample(input logic [SW-1:0] raw);
		longint          s;
		longint          c;
		longint          mix;
		longint          y;
		longint unsigned mag;
		longint unsigned gain;
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned fr;
		longint unsigned t;
		if (bypass_set != 0)
			return raw;
		s = longint'($signed(raw));
		gain = 65536 + 3 * drive_set;
		mag = (s < 0) ? -s : s;
		pos = (mag * gain * TANH_DEPTH) >> (FRAC + 2);
		idx = pos >> 16;
		fr = pos & 64'hFFFF;
		if (idx >= TANH_DEPTH)
			t = tanh_rom[TANH_DEPTH];
		else
			t = tanh_rom[idx] + (((tanh_rom[idx + 1] - tanh_rom[idx]) * fr) >> 16);
		c = longint'((t + (64'd1 << (32 - FRAC))) >> (33 - FRAC));
		if (s < 0)
			c = -c;
		stage1_mem = c + ((longint'(coeff_set) * (stage1_mem - c)) >>> 16);
		stage2_mem = stage1_mem + ((longint'(coeff_set) * (stage2_mem - stage1_mem)) >>> 16);
		mix = c + ((longint'(tone_set) * (stage2_mem - c)) >>> 16);
		y = (mix * longint'(level_set)) >>> 15;
		if (y > SAMPLE_MAX)
			y = SAMPLE_MAX;
		if (y < SAMPLE_MIN)
			y = SAMPLE_MIN;
		return y[SW-1:0];
	endfunction

	// transfers on both channels, predicted and checked at the rising edge
	always @(posedge clk) begin
		audio_t want;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				wet_q.push_back('{sample: shape_sample(in_if.in_sample),
					last: in_if.block_last});
				dry_q.delete(0);
				dry_taken = 1'b1;
			end
			if (out_if.valid && out_if.ready) begin
				if (wet_q.size() == 0) begin
					report("result with nothing pending",
						longint'($signed(out_if.out_sample)), 0);
				end else begin
					want = wet_q.pop_front();
					if (out_if.out_sample !== want.sample)
						report("out_sample", longint'($signed(out_if.out_sample)),
							longint'($signed(want.sample)));
					if (out_if.out_block_last !== want.last)
						report("out_block_last", longint'(out_if.out_block_last),
							longint'(want.last));
				end
			end
		end
	end

	// sample source: bursts and gaps, holds the item until its transfer
	always @(negedge clk) begin
		if (arst_n && !(in_if.valid && !dry_taken)) begin
			dry_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_if.valid <= 1'b0;
			end else if (dry_q.size() > 0) begin
				in_if.valid      <= 1'b1;
				in_if.in_sample  <= dry_q[0].sample;
				in_if.block_last <= dry_q[0].last;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
				end
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// result sink: picks a new stall mode at random once the current one runs out
	always @(negedge clk) begin
		if (rx_left <= 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 400);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:  out_if.ready <= 1'b1;
			RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: out_if.ready <= ($urandom_range(0, 5) == 0);
			default:  out_if.ready <= ((rx_tick % 11) < 4);
		endcase
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DRIVE:  drive_set = int'(val[15:0]);
			REG_TONE:   tone_set = int'(val[15:0]);
			REG_LEVEL:  level_set = int'(val[15:0]);
			REG_COEFF:  coeff_set = int'(val[15:0]);
			REG_BYPASS: bypass_set = int'(val[0]);
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [2:0]  idx;
		logic [31:0] want;
		for (int i = REG_DRIVE; i <= REG_BYPASS; i++) begin
			idx = i[2:0];
			case (idx)
				REG_DRIVE: want = drive_set;
				REG_TONE:  want = tone_set;
				REG_LEVEL: want = level_set;
				REG_COEFF: want = coeff_set;
				default:   want = bypass_set;
			endcase
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {idx, 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== want)
				report("register readback", longint'(prdata), longint'(want));
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// upper bits carry junk half the time; only the low bits must stick
	task automatic cfg_all(input logic [15:0] drive, input logic [15:0] tone,
		input logic [15:0] level, input logic [15:0] coeff, input logic bypass);
		logic [31:0] junk;
		junk = $urandom_range(0, 1) ? $urandom : 32'd0;
		cfg_write(REG_DRIVE, {junk[31:16], drive});
		cfg_write(REG_TONE, {junk[31:16], tone});
		cfg_write(REG_LEVEL, {junk[31:16], level});
		cfg_write(REG_COEFF, {junk[31:16], coeff});
		cfg_write(REG_BYPASS, {junk[31:1], bypass});
		check_regs();
	endtask

	task automatic push_dry(input logic [SW-1:0] s, input logic last);
		dry_q.push_back('{sample: s, last: last});
	endtask

	task automatic drain();
		while (dry_q.size() != 0 || wet_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_amount();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int            n;
		int            k;
		int            v;
		logic [SW-1:0] s;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		in_if.valid      = 1'b0;
		in_if.in_sample  = '0;
		in_if.block_last = 1'b0;
		out_if.ready     = 1'b0;
		build_tanh_rom();
		drive_set  = int'(DRIVE_RST);
		tone_set   = int'(TONE_RST);
		level_set  = int'(LEVEL_RST);
		coeff_set  = int'(COEFF_RST);
		bypass_set = 0;
		stage1_mem = 0;
		stage2_mem = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_regs();
		push_dry(24'h000000, 1'b0);
		push_dry(24'h000001, 1'b0);
		push_dry(24'hFFFFFF, 1'b0);
		push_dry(24'h7FFFFF, 1'b0);
		push_dry(24'h800000, 1'b1);
		push_dry(24'h001000, 1'b0);
		push_dry(24'hFFF000, 1'b0);
		push_dry(24'h200000, 1'b0);
		push_dry(24'hD00000, 1'b1);
		push_dry(24'h555555, 1'b0);
		drain();

		cfg_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		push_dry(24'h7FFFFF, 1'b1);
		push_dry(24'h800000, 1'b0);
		push_dry(24'h123456, 1'b1);
		drain();

		// unmapped addresses must leave every register alone
		for (int i = REG_BYPASS + 1; i < 8; i++)
			cfg_write(i[2:0], $urandom);
		check_regs();

		// full drive, tone, level and smoothing; level overflow saturates
		cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		push_dry(24'h7FFFFF, 1'b0);
		push_dry(24'h800000, 1'b0);
		push_dry(24'h000001, 1'b1);
		push_dry(24'hFFFFFF, 1'b0);
		push_dry(24'h400000, 1'b0);
		push_dry(24'hAAAAAA, 1'b1);
		drain();

		cfg_all(pick_amount(), pick_amount(), pick_amount(), 16'hFFFF, 1'b1);
		push_dry(24'h7FFFFF, 1'b0);
		push_dry(24'h800000, 1'b1);
		push_dry(24'h123456, 1'b0);
		drain();

		for (int p = 0; p < 8; p++) begin
			cfg_all(pick_amount(), pick_amount(), pick_amount(), pick_amount(),
				$urandom_range(0, 5) == 0);
			n = $urandom_range(140, 210);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0: begin
						case ($urandom_range(0, 3))
							0:       s = 24'h7FFFFF;
							1:       s = 24'h800000;
							2:       s = 24'hFFFFFF;
							default: s = 24'h000001;
						endcase
					end
					1, 2, 3: begin
						k = $urandom_range(0, 22);
						v = int'($urandom & ((32'd1 << k) - 1));
						if ($urandom_range(0, 1) == 1)
							v = -v;
						s = v[SW-1:0];
					end
					default: s = SW'($urandom);
				endcase
				push_dry(s, $urandom_range(0, 7) == 0);
			end
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
